// ===== rtl/core/ffa_pkg.sv =====
// Shared types, codes and constants of the first-fit block allocator.
`default_nettype none
package ffa_pkg;

   localparam int OFF_W   = 25;
   localparam int OWN_W   = 16;
   localparam int SLOT_W  = 8;
   localparam int SLACK_W = 16;
   localparam int STAT_W  = 2;
   localparam int KIND_W  = 2;
   localparam int CSR_W   = 25;

   localparam logic [KIND_W-1:0] REQ_ALLOC  = 2'd0;
   localparam logic [KIND_W-1:0] REQ_FREE   = 2'd1;
   localparam logic [KIND_W-1:0] REQ_RESIZE = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
   localparam logic [STAT_W-1:0] ST_POOL_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_TABLE_FULL = 2'd2;
   localparam logic [STAT_W-1:0] ST_INVALID    = 2'd3;

   localparam logic CSR_POOL_SIZE   = 1'b0;
   localparam logic CSR_MERGE_SLACK = 1'b1;

   localparam logic [OFF_W-1:0]   POOL_SIZE_RST   = 25'd20971520;
   localparam logic [SLACK_W-1:0] MERGE_SLACK_RST = 16'(2 * 4096);

   typedef struct packed {
      logic [KIND_W-1:0] req_type;
      logic [OFF_W-1:0]  req_size;
      logic [SLOT_W-1:0] slot;
      logic [OWN_W-1:0]  owner_tag;
   } ffa_req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [OFF_W-1:0]  offset;
      logic [OFF_W-1:0]  granted_size;
      logic [SLOT_W-1:0] slot_out;
      logic              moved_valid;
      logic [OWN_W-1:0]  moved_owner;
   } ffa_rsp_type;

   typedef struct packed {
      logic [OFF_W-1:0] off;
      logic [OFF_W-1:0] size;
      logic [OWN_W-1:0] owner;
   } ffa_used_type;

   typedef struct packed {
      logic [OFF_W-1:0] off;
      logic [OFF_W-1:0] size;
   } ffa_hole_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_DECODE, OP_FLAST, OP_SCAN0, OP_FSCAN, OP_FNEXT, OP_TRIM,
      OP_FTAIL, OP_INS0, OP_INS, OP_INSPUT, OP_RM0, OP_RM, OP_RMEND, OP_ACHECK,
      OP_ASCAN, OP_AFIT, OP_ATAKE, OP_ATOP, OP_AWRITE, OP_OUT
   } ffa_op_type;

   typedef struct packed {
      ffa_op_type op;
   } ffa_cmd_type;

   typedef struct packed {
      logic is_alloc;
      logic is_resize;
      logic invalid;
      logic keep;
      logic holes_empty;
      logic scan_more;
      logic f_lt;
      logic f_eq_lo;
      logic f_eq_hi;
      logic below_top;
      logic trim_rm;
      logic pool_full;
      logic a_fit;
      logic tbl_full;
      logic whole;
      logic ins_zero;
      logic ins_last;
      logic rm_zero;
      logic rm_last;
   } ffa_sts_type;

endpackage
`default_nettype wire

// ===== rtl/core/ffa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module ffa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

// ===== rtl/core/ffa_datapath.sv =====
// Datapath of the allocator: tables, counters, working registers and result register.
`default_nettype none
module ffa_datapath import ffa_pkg::*; #(
   parameter int MAX_ENTRIES = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ffa_cmd_type       cmd,
   output ffa_sts_type            sts,
   input  wire ffa_req_type       req_data,
   output ffa_rsp_type            rsp_data,
   input  wire logic              csr_wr_en,
   input  wire logic              csr_index,
   input  wire logic [CSR_W-1:0]  csr_wr_data
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CW    = CNT_W + 2;
   localparam logic [CW-1:0] MAX_C = CW'(MAX_ENTRIES);

   logic [OFF_W-1:0]   pool_size_ff, pool_size_in;
   logic [SLACK_W-1:0] merge_slack_ff, merge_slack_in;
   logic [CNT_W-1:0]   used_count_ff, used_count_in;
   logic [CNT_W-1:0]   hole_count_ff, hole_count_in;
   logic [OFF_W-1:0]   top_used_ff, top_used_in;

   ffa_req_type        req_ff, req_in;
   logic [OFF_W-1:0]   blk_off_ff, blk_off_in;
   logic [OFF_W-1:0]   blk_size_ff, blk_size_in;
   logic [OWN_W-1:0]   owner_ff, owner_in;
   logic [OFF_W-1:0]   h_off_ff, h_off_in;
   logic [OFF_W-1:0]   h_size_ff, h_size_in;
   logic [OFF_W-1:0]   grant_ff, grant_in;
   logic               whole_ff, whole_in;
   logic               rm_next_ff, rm_next_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   wptr_ff, wptr_in;
   logic [CNT_W-1:0]   ins_pos_ff, ins_pos_in;
   logic [CNT_W-1:0]   rm_base_ff, rm_base_in;
   logic [1:0]         rm_d_ff, rm_d_in;
   ffa_rsp_type        res_ff, res_in;
   ffa_rsp_type        rsp_ff, rsp_in;

   logic               used_we;
   logic [IDX_W-1:0]   used_wa, used_ra;
   ffa_used_type       used_wd, used_rd;
   logic               hole_we;
   logic [IDX_W-1:0]   hole_wa, hole_ra;
   ffa_hole_type       hole_wd, hole_rd;

   logic [OFF_W:0]     blk_end;
   logic [OFF_W:0]     alloc_end;
   logic [OFF_W:0]     slack_sum;
   logic [OFF_W:0]     trim_end;
   logic [CNT_W:0]     idx_next;
   logic [CNT_W:0]     rm_src;
   logic [CW-1:0]      need;
   logic [CNT_W-1:0]   last_slot;
   logic               trim_hit;

   ffa_ram #(.WIDTH($bits(ffa_used_type)), .DEPTH(MAX_ENTRIES)) u_used_ram (
      .clock  (clock),
      .wr_en  (used_we),
      .wr_addr(used_wa),
      .wr_data(used_wd),
      .rd_addr(used_ra),
      .rd_data(used_rd)
   );

   ffa_ram #(.WIDTH($bits(ffa_hole_type)), .DEPTH(MAX_ENTRIES)) u_hole_ram (
      .clock  (clock),
      .wr_en  (hole_we),
      .wr_addr(hole_wa),
      .wr_data(hole_wd),
      .rd_addr(hole_ra),
      .rd_data(hole_rd)
   );

   assign blk_end   = {1'b0, blk_off_ff} + {1'b0, blk_size_ff};
   assign alloc_end = {1'b0, top_used_ff} + {1'b0, req_ff.req_size};
   assign slack_sum = {1'b0, req_ff.req_size} + (OFF_W + 1)'(merge_slack_ff);
   assign trim_end  = {1'b0, h_off_ff} + {1'b0, h_size_ff};
   assign idx_next  = {1'b0, idx_ff} + (CNT_W + 1)'(1);
   assign last_slot = used_count_ff - CNT_W'(1);
   assign trim_hit  = trim_end == {1'b0, top_used_ff};
   assign need      = CW'(used_count_ff) + CW'(hole_count_ff) - CW'(whole_ff) + CW'(1);
   assign rsp_data  = rsp_ff;

   always_comb begin
      sts.is_alloc    = req_ff.req_type == REQ_ALLOC;
      sts.is_resize   = req_ff.req_type == REQ_RESIZE;
      case (req_ff.req_type)
         REQ_ALLOC: sts.invalid = req_ff.req_size == '0;
         REQ_FREE, REQ_RESIZE: sts.invalid = 32'(req_ff.slot) >= 32'(used_count_ff);
         default: sts.invalid = 1'b1;
      endcase
      sts.keep        = sts.is_resize && (req_ff.req_size <= used_rd.size);
      sts.holes_empty = hole_count_ff == '0;
      sts.scan_more   = idx_next < {1'b0, hole_count_ff};
      sts.f_lt        = blk_end < {1'b0, hole_rd.off};
      sts.f_eq_lo     = blk_end == {1'b0, hole_rd.off};
      sts.f_eq_hi     = {1'b0, blk_off_ff} == ({1'b0, hole_rd.off} + {1'b0, hole_rd.size});
      sts.below_top   = blk_end < {1'b0, top_used_ff};
      sts.trim_rm     = trim_hit || rm_next_ff;
      sts.pool_full   = alloc_end >= {1'b0, pool_size_ff};
      sts.a_fit       = req_ff.req_size <= hole_rd.size;
      sts.tbl_full    = need > MAX_C;
      sts.whole       = whole_ff;
      sts.ins_zero    = hole_count_ff == ins_pos_ff;
      sts.ins_last    = (wptr_ff - CNT_W'(1)) == ins_pos_ff;
      rm_src          = {1'b0, rm_base_ff} + (CNT_W + 1)'(rm_d_ff);
      sts.rm_zero     = rm_src >= {1'b0, hole_count_ff};
      sts.rm_last     = ({1'b0, wptr_ff} + (CNT_W + 1)'(rm_d_ff))
                        == ({1'b0, hole_count_ff} - (CNT_W + 1)'(1));
   end

   always_comb begin
      pool_size_in   = pool_size_ff;
      merge_slack_in = merge_slack_ff;
      used_count_in  = used_count_ff;
      hole_count_in  = hole_count_ff;
      top_used_in    = top_used_ff;
      req_in         = req_ff;
      blk_off_in     = blk_off_ff;
      blk_size_in    = blk_size_ff;
      owner_in       = owner_ff;
      h_off_in       = h_off_ff;
      h_size_in      = h_size_ff;
      grant_in       = grant_ff;
      whole_in       = whole_ff;
      rm_next_in     = rm_next_ff;
      idx_in         = idx_ff;
      wptr_in        = wptr_ff;
      ins_pos_in     = ins_pos_ff;
      rm_base_in     = rm_base_ff;
      rm_d_in        = rm_d_ff;
      res_in         = res_ff;
      rsp_in         = rsp_ff;
      used_we        = 1'b0;
      used_wa        = IDX_W'(req_ff.slot);
      used_wd        = used_rd;
      used_ra        = IDX_W'(req_data.slot);
      hole_we        = 1'b0;
      hole_wa        = IDX_W'(idx_ff);
      hole_wd        = hole_rd;
      hole_ra        = '0;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_POOL_SIZE:   pool_size_in   = csr_wr_data[OFF_W-1:0];
            CSR_MERGE_SLACK: merge_slack_in = csr_wr_data[SLACK_W-1:0];
            default: ;
         endcase
      end

      case (cmd.op)
         OP_LOAD: begin
            req_in = req_data;
            res_in = '0;
         end
         OP_DECODE: begin
            used_ra     = IDX_W'(last_slot);
            blk_off_in  = used_rd.off;
            blk_size_in = used_rd.size;
            owner_in    = sts.is_alloc ? req_ff.owner_tag : used_rd.owner;
            if (sts.invalid) begin
               res_in.status = ST_INVALID;
            end else if (sts.keep) begin
               res_in.offset       = used_rd.off;
               res_in.granted_size = used_rd.size;
               res_in.slot_out     = req_ff.slot;
            end
         end
         OP_FLAST: begin
            if (32'(req_ff.slot) < 32'(last_slot)) begin
               used_we            = 1'b1;
               res_in.moved_valid = 1'b1;
               res_in.moved_owner = used_rd.owner;
            end
            used_count_in = last_slot;
         end
         OP_SCAN0: begin
            idx_in = '0;
         end
         OP_FSCAN: begin
            hole_ra = IDX_W'(idx_next);
            if (sts.f_lt) begin
               ins_pos_in = idx_ff;
            end else if (sts.f_eq_lo) begin
               h_off_in   = blk_off_ff;
               h_size_in  = hole_rd.size + blk_size_ff;
               rm_next_in = 1'b0;
            end else if (sts.f_eq_hi) begin
               h_off_in  = hole_rd.off;
               h_size_in = hole_rd.size + blk_size_ff;
            end else begin
               idx_in = idx_next[CNT_W-1:0];
            end
         end
         OP_FNEXT: begin
            rm_next_in = sts.scan_more && ({1'b0, hole_rd.off} == blk_end);
            if (rm_next_in) begin
               h_size_in = h_size_ff + hole_rd.size;
            end
         end
         OP_TRIM: begin
            if (trim_hit) begin
               top_used_in = top_used_ff - h_size_ff;
               rm_base_in  = idx_ff;
               rm_d_in     = rm_next_ff ? 2'd2 : 2'd1;
            end else begin
               hole_we    = 1'b1;
               hole_wd    = '{off: h_off_ff, size: h_size_ff};
               rm_base_in = idx_next[CNT_W-1:0];
               rm_d_in    = 2'd1;
            end
         end
         OP_FTAIL: begin
            if (sts.below_top) begin
               ins_pos_in = hole_count_ff;
            end else begin
               top_used_in = top_used_ff - blk_size_ff;
            end
         end
         OP_INS0: begin
            hole_ra = IDX_W'(hole_count_ff - CNT_W'(1));
            wptr_in = hole_count_ff;
         end
         OP_INS: begin
            hole_we = 1'b1;
            hole_wa = IDX_W'(wptr_ff);
            hole_ra = IDX_W'(wptr_ff - CNT_W'(2));
            wptr_in = wptr_ff - CNT_W'(1);
         end
         OP_INSPUT: begin
            hole_we       = 1'b1;
            hole_wa       = IDX_W'(ins_pos_ff);
            hole_wd       = '{off: blk_off_ff, size: blk_size_ff};
            hole_count_in = hole_count_ff + CNT_W'(1);
         end
         OP_RM0: begin
            hole_ra = IDX_W'(rm_src);
            wptr_in = rm_base_ff;
         end
         OP_RM: begin
            hole_we = 1'b1;
            hole_wa = IDX_W'(wptr_ff);
            hole_ra = IDX_W'({1'b0, wptr_ff} + (CNT_W + 1)'(rm_d_ff) + (CNT_W + 1)'(1));
            wptr_in = wptr_ff + CNT_W'(1);
         end
         OP_RMEND: begin
            hole_count_in = hole_count_ff - CNT_W'(rm_d_ff);
         end
         OP_ACHECK: begin
            whole_in = 1'b0;
            if (sts.pool_full) begin
               res_in.status = ST_POOL_FULL;
            end
         end
         OP_ASCAN: begin
            hole_ra = IDX_W'(idx_next);
            if (sts.a_fit) begin
               h_off_in  = hole_rd.off;
               h_size_in = hole_rd.size;
            end else begin
               idx_in = idx_next[CNT_W-1:0];
            end
         end
         OP_AFIT: begin
            grant_in = (slack_sum >= {1'b0, h_size_ff}) ? h_size_ff : req_ff.req_size;
            whole_in = grant_in == h_size_ff;
         end
         OP_ATAKE: begin
            if (sts.tbl_full) begin
               res_in.status = ST_TABLE_FULL;
            end else if (whole_ff) begin
               rm_base_in = idx_ff;
               rm_d_in    = 2'd1;
            end else begin
               hole_we = 1'b1;
               hole_wd = '{off: h_off_ff + grant_ff, size: h_size_ff - grant_ff};
            end
         end
         OP_ATOP: begin
            if (sts.tbl_full) begin
               res_in.status = ST_TABLE_FULL;
            end else begin
               h_off_in    = top_used_ff;
               top_used_in = alloc_end[OFF_W-1:0];
               grant_in    = req_ff.req_size;
            end
         end
         OP_AWRITE: begin
            used_we             = 1'b1;
            used_wa             = IDX_W'(used_count_ff);
            used_wd             = '{off: h_off_ff, size: grant_ff, owner: owner_ff};
            res_in.status       = ST_OK;
            res_in.offset       = h_off_ff;
            res_in.granted_size = grant_ff;
            res_in.slot_out     = SLOT_W'(used_count_ff);
            used_count_in       = used_count_ff + CNT_W'(1);
         end
         OP_OUT: begin
            rsp_in = res_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_size_ff   <= POOL_SIZE_RST;
         merge_slack_ff <= MERGE_SLACK_RST;
         used_count_ff  <= '0;
         hole_count_ff  <= '0;
         top_used_ff    <= '0;
      end else begin
         pool_size_ff   <= pool_size_in;
         merge_slack_ff <= merge_slack_in;
         used_count_ff  <= used_count_in;
         hole_count_ff  <= hole_count_in;
         top_used_ff    <= top_used_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      blk_off_ff  <= blk_off_in;
      blk_size_ff <= blk_size_in;
      owner_ff    <= owner_in;
      h_off_ff    <= h_off_in;
      h_size_ff   <= h_size_in;
      grant_ff    <= grant_in;
      whole_ff    <= whole_in;
      rm_next_ff  <= rm_next_in;
      idx_ff      <= idx_in;
      wptr_ff     <= wptr_in;
      ins_pos_ff  <= ins_pos_in;
      rm_base_ff  <= rm_base_in;
      rm_d_ff     <= rm_d_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

endmodule
`default_nettype wire

// ===== rtl/core/ffa_ctrl.sv =====
// Controller state machine of the allocator: sequences the datapath per transaction.
`default_nettype none
module ffa_ctrl import ffa_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output ffa_cmd_type      cmd,
   input  wire ffa_sts_type sts
);

   typedef enum logic [20:0] {
      S_IDLE   = 21'h000001,
      S_DECODE = 21'h000002,
      S_FLAST  = 21'h000004,
      S_SCAN0  = 21'h000008,
      S_FSCAN  = 21'h000010,
      S_FNEXT  = 21'h000020,
      S_TRIM   = 21'h000040,
      S_FTAIL  = 21'h000080,
      S_INS0   = 21'h000100,
      S_INS    = 21'h000200,
      S_INSPUT = 21'h000400,
      S_RM0    = 21'h000800,
      S_RM     = 21'h001000,
      S_RMEND  = 21'h002000,
      S_ACHECK = 21'h004000,
      S_ASCAN  = 21'h008000,
      S_AFIT   = 21'h010000,
      S_ATAKE  = 21'h020000,
      S_ATOP   = 21'h040000,
      S_AWRITE = 21'h080000,
      S_DONE   = 21'h100000
   } ffa_state_type;

   ffa_state_type state_ff, state_in;
   logic          in_alloc_ff, in_alloc_in;
   logic          rsp_valid_ff, rsp_valid_in;
   ffa_state_type free_done;
   logic          out_free;

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign free_done = sts.is_resize ? S_ACHECK : S_DONE;

   always_comb begin
      state_in     = state_ff;
      in_alloc_in  = in_alloc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.op       = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            in_alloc_in = 1'b0;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.op = OP_DECODE;
            if (sts.invalid || sts.keep) begin
               state_in = S_DONE;
            end else if (sts.is_alloc) begin
               state_in = S_ACHECK;
            end else begin
               state_in = S_FLAST;
            end
         end
         S_FLAST: begin
            cmd.op   = OP_FLAST;
            state_in = S_SCAN0;
         end
         S_SCAN0: begin
            cmd.op = OP_SCAN0;
            if (sts.holes_empty) begin
               state_in = in_alloc_ff ? S_ATOP : S_FTAIL;
            end else begin
               state_in = in_alloc_ff ? S_ASCAN : S_FSCAN;
            end
         end
         S_FSCAN: begin
            cmd.op = OP_FSCAN;
            if (sts.f_lt) begin
               state_in = S_INS0;
            end else if (sts.f_eq_lo) begin
               state_in = S_TRIM;
            end else if (sts.f_eq_hi) begin
               state_in = S_FNEXT;
            end else if (!sts.scan_more) begin
               state_in = S_FTAIL;
            end
         end
         S_FNEXT: begin
            cmd.op   = OP_FNEXT;
            state_in = S_TRIM;
         end
         S_TRIM: begin
            cmd.op   = OP_TRIM;
            state_in = sts.trim_rm ? S_RM0 : free_done;
         end
         S_FTAIL: begin
            cmd.op   = OP_FTAIL;
            state_in = sts.below_top ? S_INS0 : free_done;
         end
         S_INS0: begin
            cmd.op   = OP_INS0;
            state_in = sts.ins_zero ? S_INSPUT : S_INS;
         end
         S_INS: begin
            cmd.op = OP_INS;
            if (sts.ins_last) begin
               state_in = S_INSPUT;
            end
         end
         S_INSPUT: begin
            cmd.op   = OP_INSPUT;
            state_in = free_done;
         end
         S_RM0: begin
            cmd.op   = OP_RM0;
            state_in = sts.rm_zero ? S_RMEND : S_RM;
         end
         S_RM: begin
            cmd.op = OP_RM;
            if (sts.rm_last) begin
               state_in = S_RMEND;
            end
         end
         S_RMEND: begin
            cmd.op   = OP_RMEND;
            state_in = in_alloc_ff ? S_AWRITE : free_done;
         end
         S_ACHECK: begin
            cmd.op      = OP_ACHECK;
            in_alloc_in = 1'b1;
            state_in    = sts.pool_full ? S_DONE : S_SCAN0;
         end
         S_ASCAN: begin
            cmd.op = OP_ASCAN;
            if (sts.a_fit) begin
               state_in = S_AFIT;
            end else if (!sts.scan_more) begin
               state_in = S_ATOP;
            end
         end
         S_AFIT: begin
            cmd.op   = OP_AFIT;
            state_in = S_ATAKE;
         end
         S_ATAKE: begin
            cmd.op = OP_ATAKE;
            if (sts.tbl_full) begin
               state_in = S_DONE;
            end else if (sts.whole) begin
               state_in = S_RM0;
            end else begin
               state_in = S_AWRITE;
            end
         end
         S_ATOP: begin
            cmd.op   = OP_ATOP;
            state_in = sts.tbl_full ? S_DONE : S_AWRITE;
         end
         S_AWRITE: begin
            cmd.op   = OP_AWRITE;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.op       = OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_alloc_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_alloc_ff  <= in_alloc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/first_fit_block_allocator_core.sv =====
// Top level of the first-fit block allocator: controller, datapath and checks.
`default_nettype none
// One transaction is handled at a time. The time a transaction occupies the block grows with
// each further hole examined in the offset-ordered hole list and with each hole shifted when a
// hole is inserted or removed, since the hole table has a single read and write port; a
// growing resize runs the free and the allocate passes back to back. A finished result waits
// in an output register, and the next transaction is taken while it waits. Table entries are
// not cleared after reset, so no clearing pass is needed.
module first_fit_block_allocator_core import ffa_pkg::*; #(
   parameter int MAX_ENTRIES = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ffa_req_type       req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output ffa_rsp_type            rsp_data,
   input  wire logic              csr_wr_en,
   input  wire logic              csr_index,
   input  wire logic [CSR_W-1:0]  csr_wr_data
);

   ffa_cmd_type dp_cmd;
   ffa_sts_type dp_sts;

   ffa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .cmd      (dp_cmd),
      .sts      (dp_sts)
   );

   ffa_datapath #(.MAX_ENTRIES(MAX_ENTRIES)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (dp_cmd),
      .sts        (dp_sts),
      .req_data   (req_data),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data)
   );

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("transaction accepted while another was in progress");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.op == OP_OUT) |=> rsp_valid)
      else $error("result register loaded without raising rsp_valid");

   a_no_load_over_waiting: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> (dp_cmd.op != OP_OUT))
      else $error("waiting result overwritten");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench of the first-fit block allocator core.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import ffa_pkg::*;

   localparam int     NSLOTS   = 256;
   localparam longint OFF_MASK = 64'd33554431;
   localparam int     WDOG_MAX = 20000;
   localparam logic [KIND_W-1:0] REQ_BAD = 2'd3;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   ffa_req_type       req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   ffa_rsp_type       rsp_data;
   logic              csr_wr_en = 1'b0;
   logic              csr_index = 1'b0;
   logic [CSR_W-1:0]  csr_wr_data = '0;

   // Model of the allocator state.
   logic [OFF_W-1:0]  blk_off  [0:NSLOTS-1];
   logic [OFF_W-1:0]  blk_size [0:NSLOTS-1];
   logic [OWN_W-1:0]  blk_own  [0:NSLOTS-1];
   int unsigned       n_used;
   int unsigned       n_holes;
   longint            top_mark;
   longint            pool_bytes;
   longint            slack_bytes;

   ffa_rsp_type       pending_rsp[$];
   int                errors = 0;
   int                wdog = 0;
   int                send_idle_pct = 0;
   int                stall_pct = 0;
   int                hold_left = 0;
   bit                hold_start = 1'b0;

   first_fit_block_allocator_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic int hslot(int unsigned h);
      return NSLOTS - 1 - h;
   endfunction

   function automatic void hole_del(int unsigned h);
      if (h >= n_holes) return;
      for (int unsigned k = h; k + 1 < n_holes; k++) begin
         blk_off[hslot(k)]  = blk_off[hslot(k + 1)];
         blk_size[hslot(k)] = blk_size[hslot(k + 1)];
      end
      n_holes--;
   endfunction

   function automatic void hole_add(int unsigned h, logic [OFF_W-1:0] off,
                                    logic [OFF_W-1:0] size);
      if (n_used + n_holes >= NSLOTS || h > n_holes) return;
      for (int unsigned k = n_holes; k > h; k--) begin
         blk_off[hslot(k)]  = blk_off[hslot(k - 1)];
         blk_size[hslot(k)] = blk_size[hslot(k - 1)];
      end
      blk_off[hslot(h)]  = off;
      blk_size[hslot(h)] = size;
      n_holes++;
   endfunction

   function automatic void trim_top(int unsigned h);
      int i;
      i = hslot(h);
      if (longint'(blk_off[i]) + blk_size[i] == top_mark) begin
         top_mark = (top_mark - blk_size[i]) & OFF_MASK;
         hole_del(h);
      end
   endfunction

   function automatic void release_blk(int unsigned slot, inout ffa_rsp_type r);
      logic [OFF_W-1:0] start, size, ho, hs;
      longint           fin;
      int unsigned      last, h;
      int               i;
      start = blk_off[slot];
      size  = blk_size[slot];
      fin   = longint'(start) + size;
      last  = n_used - 1;
      if (slot < last) begin
         blk_off[slot]  = blk_off[last];
         blk_size[slot] = blk_size[last];
         blk_own[slot]  = blk_own[last];
         r.moved_valid  = 1'b1;
         r.moved_owner  = blk_own[last];
      end
      n_used--;
      for (h = 0; h < n_holes; h++) begin
         i  = hslot(h);
         ho = blk_off[i];
         hs = blk_size[i];
         if (fin < ho) begin
            hole_add(h, start, size);
            return;
         end
         if (fin == ho) begin
            blk_off[i]  = start;
            blk_size[i] = hs + size;
            if (h > 0 && longint'(blk_off[hslot(h - 1)]) + blk_size[hslot(h - 1)] == start) begin
               blk_size[hslot(h - 1)] = blk_size[hslot(h - 1)] + blk_size[i];
               hole_del(h);
               h--;
            end
            trim_top(h);
            return;
         end
         if (longint'(start) == longint'(ho) + hs) begin
            blk_size[i] = hs + size;
            if (h + 1 < n_holes && longint'(blk_off[hslot(h + 1)]) == fin) begin
               blk_size[i] = blk_size[i] + blk_size[hslot(h + 1)];
               hole_del(h + 1);
            end
            trim_top(h);
            return;
         end
      end
      if (fin < top_mark) hole_add(n_holes, start, size);
      else top_mark = (top_mark - size) & OFF_MASK;
   endfunction

   function automatic logic [STAT_W-1:0] grant_blk(logic [OFF_W-1:0] size_in,
                                                  logic [OWN_W-1:0] owner,
                                                  inout ffa_rsp_type r);
      logic [OFF_W-1:0] size, off, hs;
      bit               found;
      int unsigned      fh, new_holes;
      int               s;
      size      = size_in;
      found     = 1'b0;
      fh        = 0;
      new_holes = n_holes;
      if (top_mark + size >= pool_bytes) return ST_POOL_FULL;
      for (int unsigned h = 0; h < n_holes; h++) begin
         if (size <= blk_size[hslot(h)]) begin
            found = 1'b1;
            fh    = h;
            break;
         end
      end
      if (found) begin
         hs = blk_size[hslot(fh)];
         if (longint'(size) + slack_bytes >= hs) size = hs;
         if (size == hs) new_holes = n_holes - 1;
      end
      if (longint'(n_used) + new_holes + 1 > NSLOTS) return ST_TABLE_FULL;
      if (found) begin
         s   = hslot(fh);
         off = blk_off[s];
         if (size == blk_size[s]) hole_del(fh);
         else begin
            blk_size[s] = blk_size[s] - size;
            blk_off[s]  = blk_off[s] + size;
         end
      end else begin
         off      = top_mark[OFF_W-1:0];
         top_mark = (top_mark + size) & OFF_MASK;
      end
      blk_off[n_used]  = off;
      blk_size[n_used] = size;
      blk_own[n_used]  = owner;
      r.offset         = off;
      r.granted_size   = size;
      r.slot_out       = n_used[SLOT_W-1:0];
      n_used++;
      return ST_OK;
   endfunction

   function automatic ffa_rsp_type predict_alloc_result(ffa_req_type q);
      ffa_rsp_type      r;
      logic [OWN_W-1:0] keep;
      r        = '0;
      r.status = ST_INVALID;
      case (q.req_type)
         REQ_ALLOC: begin
            if (q.req_size != 0) r.status = grant_blk(q.req_size, q.owner_tag, r);
         end
         REQ_FREE: begin
            if (q.slot < n_used) begin
               release_blk(q.slot, r);
               r.status = ST_OK;
            end
         end
         REQ_RESIZE: begin
            if (q.slot < n_used) begin
               if (q.req_size <= blk_size[q.slot]) begin
                  r.offset       = blk_off[q.slot];
                  r.granted_size = blk_size[q.slot];
                  r.slot_out     = q.slot;
                  r.status       = ST_OK;
               end else begin
                  keep = blk_own[q.slot];
                  release_blk(q.slot, r);
                  r.status = grant_blk(q.req_size, keep, r);
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_req(input logic [KIND_W-1:0] kind, input logic [OFF_W-1:0] size,
                           input logic [SLOT_W-1:0] slot, input logic [OWN_W-1:0] owner);
      ffa_req_type q;
      q.req_type  = kind;
      q.req_size  = size;
      q.slot      = slot;
      q.owner_tag = owner;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      do @(posedge clock); while (req_stall);
      pending_rsp.push_back(predict_alloc_result(q));
   endtask

   task automatic drain_and_idle();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [CSR_W-1:0] val);
      drain_and_idle();
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      if (idx == CSR_POOL_SIZE) pool_bytes = longint'(val);
      else slack_bytes = longint'(val[SLACK_W-1:0]);
   endtask

   task automatic send_random_req(input int max_size);
      int pick;
      logic [OFF_W-1:0] size;
      pick = int'($urandom_range(99));
      if ($urandom_range(9) == 0) size = OFF_W'($urandom());
      else size = OFF_W'($urandom_range(max_size, 1));
      if (n_used == 0 && pick < 60) pick = 0;
      if (pick < 45)
         send_req(REQ_ALLOC, size, SLOT_W'($urandom()), OWN_W'($urandom()));
      else if (pick < 78)
         send_req(REQ_FREE, OFF_W'($urandom()),
                  SLOT_W'($urandom_range(n_used == 0 ? 0 : n_used - 1)), OWN_W'($urandom()));
      else if (pick < 94)
         send_req(REQ_RESIZE, size, SLOT_W'($urandom_range(n_used == 0 ? 0 : n_used - 1)),
                  OWN_W'($urandom()));
      else
         send_req(KIND_W'($urandom_range(3)), size, SLOT_W'($urandom()), OWN_W'($urandom()));
   endtask

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else if (hold_start) begin
         hold_start = 1'b0;
         hold_left  = 3000;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic report(input string field, input longint exp_v, input longint act_v);
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, exp_v, act_v);
   endtask

   always @(posedge clock) begin
      ffa_rsp_type want;
      if (!reset) begin
         wdog++;
         if (req_valid && !req_stall) wdog = 0;
         if (rsp_valid && !rsp_stall) begin
            wdog = 0;
            if (pending_rsp.size() == 0) begin
               errors++;
               $display("%0t: unexpected transaction, actual %h", $time, rsp_data);
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.status !== want.status)
                  report("status", longint'(want.status), longint'(rsp_data.status));
               if (rsp_data.offset !== want.offset)
                  report("offset", longint'(want.offset), longint'(rsp_data.offset));
               if (rsp_data.granted_size !== want.granted_size)
                  report("granted_size", longint'(want.granted_size),
                         longint'(rsp_data.granted_size));
               if (rsp_data.slot_out !== want.slot_out)
                  report("slot_out", longint'(want.slot_out), longint'(rsp_data.slot_out));
               if (rsp_data.moved_valid !== want.moved_valid)
                  report("moved_valid", longint'(want.moved_valid),
                         longint'(rsp_data.moved_valid));
               if (rsp_data.moved_owner !== want.moved_owner)
                  report("moved_owner", longint'(want.moved_owner),
                         longint'(rsp_data.moved_owner));
            end
         end
         if (wdog > WDOG_MAX) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   task automatic test_directed();
      send_req(REQ_BAD, 25'd100, 8'd0, 16'd1);
      send_req(REQ_ALLOC, 25'd0, 8'd0, 16'd1);
      send_req(REQ_FREE, 25'd0, 8'd0, 16'd1);
      send_req(REQ_RESIZE, 25'd10, 8'd255, 16'd1);
      send_req(REQ_ALLOC, 25'h1FFFFFF, 8'hFF, 16'hFFFF);
      send_req(REQ_ALLOC, 25'd1, 8'd0, 16'h0000);
      send_req(REQ_ALLOC, 25'd20000, 8'd0, 16'hFFFF);
      send_req(REQ_ALLOC, 25'd30000, 8'd0, 16'h1234);
      send_req(REQ_ALLOC, 25'd40000, 8'd0, 16'h5678);
      send_req(REQ_ALLOC, 25'd50000, 8'd0, 16'h9ABC);
      send_req(REQ_RESIZE, 25'd15000, 8'd1, 16'd0);
      send_req(REQ_FREE, 25'd0, 8'd1, 16'd0);
      send_req(REQ_FREE, 25'd0, 8'd2, 16'd0);
      send_req(REQ_ALLOC, 25'd5000, 8'd0, 16'hAAAA);
      send_req(REQ_ALLOC, 25'd25000, 8'd0, 16'h5555);
      send_req(REQ_RESIZE, 25'd90000, 8'd0, 16'd0);
      send_req(REQ_FREE, 25'd0, 8'd1, 16'd0);
      send_req(REQ_FREE, 25'd0, 8'd0, 16'd0);
      send_req(REQ_FREE, 25'd0, 8'd4, 16'd0);
      send_req(REQ_RESIZE, 25'h1FFFFFF, 8'd0, 16'd0);
      while (n_used > 0) send_req(REQ_FREE, 25'd0, 8'(n_used - 1), 16'd0);
   endtask

   task automatic test_small_pool();
      write_csr(CSR_POOL_SIZE, 25'd4096);
      write_csr(CSR_MERGE_SLACK, 25'd0);
      repeat (6) send_req(REQ_ALLOC, 25'd1000, 8'd0, OWN_W'($urandom()));
      send_req(REQ_FREE, 25'd0, 8'd1, 16'd0);
      send_req(REQ_ALLOC, 25'd999, 8'd0, 16'd7);
      send_req(REQ_ALLOC, 25'd1, 8'd0, 16'd8);
      while (n_used > 0)
         send_req(REQ_FREE, 25'd0, SLOT_W'($urandom_range(n_used - 1)), 16'd0);
   endtask

   task automatic test_table_full();
      write_csr(CSR_POOL_SIZE, 25'h1FFFFFF);
      write_csr(CSR_MERGE_SLACK, 25'hFFFF);
      repeat (NSLOTS + 2)
         send_req(REQ_ALLOC, OFF_W'($urandom_range(16, 1)), 8'd0, OWN_W'($urandom()));
      for (int k = 0; k < 40; k++)
         send_req(REQ_FREE, 25'd0, SLOT_W'($urandom_range(n_used - 1)), 16'd0);
      repeat (60) send_random_req(30);
      while (n_used > 0)
         send_req(REQ_FREE, 25'd0, SLOT_W'($urandom_range(n_used - 1)), 16'd0);
   endtask

   task automatic test_random(input int n, input int idle, input int stall,
                              input logic [CSR_W-1:0] pool, input logic [CSR_W-1:0] slack);
      write_csr(CSR_POOL_SIZE, pool);
      write_csr(CSR_MERGE_SLACK, slack);
      send_idle_pct = idle;
      stall_pct     = stall;
      repeat (n) send_random_req(40000);
      send_idle_pct = 0;
      stall_pct     = 0;
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      @(posedge clock);
      hold_start = 1'b1;
      repeat (30) send_random_req(40000);
   endtask

   initial begin
      for (int k = 0; k < NSLOTS; k++) begin
         blk_off[k]  = '0;
         blk_size[k] = '0;
         blk_own[k]  = '0;
      end
      n_used      = 0;
      n_holes     = 0;
      top_mark    = 0;
      pool_bytes  = longint'(POOL_SIZE_RST);
      slack_bytes = longint'(MERGE_SLACK_RST);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_small_pool();
      test_table_full();
      test_random(60, 0, 0, 25'd20971520, 25'd8192);
      test_random(60, 65, 0, 25'h1FFFFFF, 25'd0);
      test_random(60, 0, 65, 25'd2000000, 25'hFFFF);
      test_random(60, 20, 20, 25'd1000000, 25'd4096);
      test_backpressure();
      drain_and_idle();
      if (errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/ffa_pkg.sv
rtl/core/ffa_ram.sv
rtl/core/ffa_datapath.sv
rtl/core/ffa_ctrl.sv
rtl/core/first_fit_block_allocator_core.sv
tb/sv/tb_top.sv
